// File: src/kcc_pkg.sv
// ----------------------------------------------------------------------------
// kcc_pkg: shared definitions for the keypad calculator controller
// Grid geometry, key layout, operation codes and stream field positions.
// ----------------------------------------------------------------------------
package kcc_pkg;

   localparam int VALUE_W    = 64;
   localparam int KEY_W      = 5;
   localparam int DIGITS_W   = 5;
   localparam int MAX_DIGITS = 15;

   // keypad geometry in pixels
   localparam int GRID_X0    = 10;
   localparam int GRID_Y0    = 50;
   localparam int CELL_W     = 30;
   localparam int CELL_H     = 25;
   localparam int CELL_GAP   = 5;
   localparam int GRID_COLS  = 4;
   localparam int GRID_ROWS  = 4;
   localparam int COL_PITCH  = CELL_W + CELL_GAP;
   localparam int ROW_PITCH  = CELL_H + CELL_GAP;

   // cell indexes with a fixed meaning
   localparam logic [KEY_W-1:0] NO_KEY     = 5'd16;
   localparam logic [KEY_W-1:0] CELL_ADD   = 5'd3;
   localparam logic [KEY_W-1:0] CELL_SUB   = 5'd7;
   localparam logic [KEY_W-1:0] CELL_CLR   = 5'd11;
   localparam logic [KEY_W-1:0] CELL_EQ    = 5'd12;
   localparam logic [KEY_W-1:0] CELL_EMPTY = 5'd15;

   // key kinds: 0..9 are digits
   localparam logic [3:0] KIND_DIGIT_MAX = 4'd9;
   localparam logic [3:0] KIND_ADD       = 4'd10;
   localparam logic [3:0] KIND_SUB       = 4'd11;
   localparam logic [3:0] KIND_CLR       = 4'd12;
   localparam logic [3:0] KIND_EQ        = 4'd13;
   localparam logic [3:0] KIND_DOT       = 4'd14;
   localparam logic [3:0] KIND_NONE      = 4'd15;

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_ADD  = 2'd1,
      OP_SUB  = 2'd2
   } op_type;

   // stream layout
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_KEY_LSB = VALUE_W;
   localparam int RSP_OP_LSB  = VALUE_W + KEY_W;

   function automatic logic [3:0] key_kind(input logic [3:0] idx);
      logic [3:0] kind;
      case (idx)
         4'd0:    kind = 4'd7;
         4'd1:    kind = 4'd8;
         4'd2:    kind = 4'd9;
         4'd3:    kind = KIND_ADD;
         4'd4:    kind = 4'd4;
         4'd5:    kind = 4'd5;
         4'd6:    kind = 4'd6;
         4'd7:    kind = KIND_SUB;
         4'd8:    kind = 4'd1;
         4'd9:    kind = 4'd2;
         4'd10:   kind = 4'd3;
         4'd11:   kind = KIND_CLR;
         4'd12:   kind = KIND_EQ;
         4'd13:   kind = 4'd0;
         4'd14:   kind = KIND_DOT;
         default: kind = KIND_NONE;
      endcase
      return kind;
   endfunction

endpackage

// File: src/keypad_calculator_controller_core.sv
// ----------------------------------------------------------------------------
// keypad_calculator_controller_core: add/subtract keypad calculator control
// Turns pointer events into key presses and keeps the calculator state.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one pointer event per transaction (position and buttons).
//   rsp_* carries exactly one result per event: the displayed value, the
//   cell hit on a primary button press (16 if none) and the pending operation.
//   An event is registered at acceptance, decoded and applied to the state
//   when it moves to the output register, which presents its result on
//   rsp_tvalid. One event per cycle is sustained while rsp_tready stays
//   high; the 64-bit add/subtract and the x10 digit append sit in the
//   single logic stage between the input and output registers.
//   When rsp_tready is low the result holds in the output register and one
//   more event can still be taken into the input register; req_tready then
//   drops until the output drains.
//   Reset (synchronous, active high) empties both registers and sets the
//   display to 0, a fresh entry and no pending operation.
// ----------------------------------------------------------------------------
module keypad_calculator_controller_core
   import kcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [15:0] pointer_x, [31:16] pointer_y, [39:32] button_mask
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [63:0] display_value, [68:64] pressed_key, [70:69] pending_operation, [71] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // input stage
   logic                  req_valid_ff;
   logic                  req_valid_in;
   logic [REQ_DATA_W-1:0] req_data_ff;
   logic                  advance;

   // calculator state
   logic                  prev_button_ff,   prev_button_in;
   logic [VALUE_W-1:0]    shown_value_ff,   shown_value_in;
   logic [DIGITS_W-1:0]   entered_digits_ff, entered_digits_in;
   logic                  starting_entry_ff, starting_entry_in;
   logic [VALUE_W-1:0]    latched_value_ff, latched_value_in;
   op_type                latched_op_ff,    latched_op_in;

   // output stage
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [KEY_W-1:0]      hit_idx;
   logic [KEY_W-1:0]      pressed;
   logic [3:0]            kind;
   logic                  click;
   logic [VALUE_W-1:0]    digit_ext;
   logic [VALUE_W-1:0]    appended;

   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !req_valid_ff || advance;
   assign req_valid_in = (req_tvalid && req_tready) || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   kcc_hit u_hit (
      .pointer_x (req_data_ff[15:0]),
      .pointer_y (req_data_ff[31:16]),
      .hit_idx   (hit_idx)
   );

   assign kind      = key_kind(hit_idx[3:0]);
   assign click     = req_data_ff[32] && !prev_button_ff;
   assign digit_ext = {{(VALUE_W-4){1'b0}}, kind};
   // shown * 10 + digit
   assign appended  = (shown_value_ff << 3) + (shown_value_ff << 1) + digit_ext;

   always_comb begin
      prev_button_in    = req_data_ff[32];
      shown_value_in    = shown_value_ff;
      entered_digits_in = entered_digits_ff;
      starting_entry_in = starting_entry_ff;
      latched_value_in  = latched_value_ff;
      latched_op_in     = latched_op_ff;
      pressed           = NO_KEY;
      if (click && !hit_idx[4] && kind != KIND_NONE) begin
         pressed = hit_idx;
         if (kind <= KIND_DIGIT_MAX) begin
            if (starting_entry_ff) begin
               shown_value_in    = digit_ext;
               entered_digits_in = DIGITS_W'(1);
               starting_entry_in = 1'b0;
            end else if (shown_value_ff == '0) begin
               // a lone zero is replaced
               shown_value_in    = digit_ext;
               entered_digits_in = DIGITS_W'(1);
            end else if (entered_digits_ff < DIGITS_W'(MAX_DIGITS)) begin
               shown_value_in    = appended;
               entered_digits_in = entered_digits_ff + DIGITS_W'(1);
            end
         end else begin
            case (kind)
               KIND_CLR: begin
                  shown_value_in    = '0;
                  entered_digits_in = DIGITS_W'(1);
                  latched_value_in  = '0;
                  latched_op_in     = OP_NONE;
                  starting_entry_in = 1'b1;
               end
               KIND_ADD, KIND_SUB: begin
                  latched_value_in  = shown_value_ff;
                  latched_op_in     = (kind == KIND_ADD) ? OP_ADD : OP_SUB;
                  starting_entry_in = 1'b1;
               end
               KIND_EQ: begin
                  case (latched_op_ff)
                     OP_ADD:  shown_value_in = latched_value_ff + shown_value_ff;
                     OP_SUB:  shown_value_in = latched_value_ff - shown_value_ff;
                     default: shown_value_in = shown_value_ff;
                  endcase
                  latched_value_in  = '0;
                  latched_op_in     = OP_NONE;
                  entered_digits_in = DIGITS_W'(1);
                  starting_entry_in = 1'b1;
               end
               default: ; // decimal point does nothing
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff      <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         prev_button_ff    <= 1'b0;
         shown_value_ff    <= '0;
         entered_digits_ff <= DIGITS_W'(1);
         starting_entry_ff <= 1'b1;
         latched_value_ff  <= '0;
         latched_op_ff     <= OP_NONE;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            prev_button_ff    <= prev_button_in;
            shown_value_ff    <= shown_value_in;
            entered_digits_ff <= entered_digits_in;
            starting_entry_ff <= starting_entry_in;
            latched_value_ff  <= latched_value_in;
            latched_op_ff     <= latched_op_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_data_ff <= req_tdata;
      end
      if (advance) begin
         rsp_data_ff <= {1'b0, latched_op_in, pressed, shown_value_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: src/kcc_hit.sv
// ----------------------------------------------------------------------------
// kcc_hit: keypad hit test
// Maps a pointer position to a grid cell index, or NO_KEY for gaps/outside.
// ----------------------------------------------------------------------------
module kcc_hit
   import kcc_pkg::*;
(
   input  logic [15:0]      pointer_x,
   input  logic [15:0]      pointer_y,
   output logic [KEY_W-1:0] hit_idx
);

   logic [16:0] dx;
   logic [16:0] dy;
   logic [1:0]  col;
   logic [1:0]  row;
   logic        col_hit;
   logic        row_hit;

   // sign extend, then offset to the grid origin; bit 16 is the sign
   assign dx = {pointer_x[15], pointer_x} - 17'(GRID_X0);
   assign dy = {pointer_y[15], pointer_y} - 17'(GRID_Y0);

   always_comb begin
      col     = '0;
      col_hit = 1'b0;
      for (int i = 0; i < GRID_COLS; i++) begin
         if (!dx[16] && dx[15:0] >= 16'(i * COL_PITCH)
             && dx[15:0] < 16'(i * COL_PITCH + CELL_W)) begin
            col     = 2'(i);
            col_hit = 1'b1;
         end
      end
   end

   always_comb begin
      row     = '0;
      row_hit = 1'b0;
      for (int j = 0; j < GRID_ROWS; j++) begin
         if (!dy[16] && dy[15:0] >= 16'(j * ROW_PITCH)
             && dy[15:0] < 16'(j * ROW_PITCH + CELL_H)) begin
            row     = 2'(j);
            row_hit = 1'b1;
         end
      end
   end

   assign hit_idx = (col_hit && row_hit) ? {1'b0, row, col} : NO_KEY;

endmodule

// File: src/kcc_checker.sv
// ----------------------------------------------------------------------------
// kcc_checker: port-level checks for the keypad calculator controller
// Watches the result stream for reset, stall and key decode consistency.
// ----------------------------------------------------------------------------
module kcc_checker
   import kcc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [KEY_W-1:0]   key;
   logic [1:0]         op;
   logic [VALUE_W-1:0] value;

   assign value = rsp_tdata[VALUE_W-1:0];
   assign key   = rsp_tdata[RSP_KEY_LSB +: KEY_W];
   assign op    = rsp_tdata[RSP_OP_LSB +: 2];

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled transaction changed");

   a_key_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> key != CELL_EMPTY && (key[4] == 1'b0 || key == NO_KEY))
      else $error("pressed key outside the keypad");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && key == CELL_CLR |-> value == '0 && op == OP_NONE)
      else $error("clear left state behind");

   a_latch_op: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (key != CELL_ADD || op == OP_ADD) && (key != CELL_SUB || op == OP_SUB)
                     && (key != CELL_EQ || op == OP_NONE))
      else $error("operation key not reflected in pending operation");

endmodule

bind keypad_calculator_controller_core kcc_checker u_kcc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
